/* hdl/flux_interval_rescaler_macros.svh */
// ----------------------------------------------------------------------------
// Flux interval rescaler assertion macros
// Shared concurrent assertion helpers; they vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FLUX_INTERVAL_RESCALER_MACROS_SVH
`define FLUX_INTERVAL_RESCALER_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every rising edge outside reset.
`define FIR_ASSERT(lbl, clk_s, rstn_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
		else $error("%m: check failed");
// Checked at every rising edge, reset included.
`define FIR_ASSERT_ALWAYS(lbl, clk_s, prop) \
	lbl: assert property (@(posedge clk_s) prop) \
		else $error("%m: check failed");
`else
`define FIR_ASSERT(lbl, clk_s, rstn_s, prop)
`define FIR_ASSERT_ALWAYS(lbl, clk_s, prop)
`endif
`endif

/* hdl/fir_pkg.sv */
// ----------------------------------------------------------------------------
// Flux interval rescaler package
// Constants, register codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fir_pkg;

	// Fixed output sample clock in hertz.
	localparam int unsigned SAMPLE_CLOCK_W = 26;
	localparam logic [SAMPLE_CLOCK_W-1:0] SAMPLE_CLOCK = 26'd40000000;

	// Field widths.
	localparam int unsigned TC_W    = 30;
	localparam int unsigned LIMIT_W = 8;
	localparam int unsigned TICKS_W = 32;
	localparam int unsigned REV_W   = 9;
	localparam int unsigned ZW_W    = 23;
	localparam int unsigned FLUX_W  = 16;
	localparam int unsigned WORD_W  = 32;

	// Dividend width: sample clock times a 32-bit count plus a 30-bit addend.
	localparam int unsigned DIV_W     = 58;
	localparam int unsigned DIV_STEPS = DIV_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	// Flux word limits.
	localparam logic [DIV_W-1:0]  FLUX_CLAMP_IN = 58'd65536;
	localparam logic [DIV_W-1:0]  FLUX_MAX      = 58'd65535;
	localparam logic [ZW_W-1:0]   ZW_MAX        = 23'd8388607;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_TRACK_CLOCK = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_REV_LIMIT   = 1'd1;

	// Reset values of the configuration registers.
	localparam logic [TC_W-1:0]    TRACK_CLOCK_RST = 30'd40000000;
	localparam logic [LIMIT_W-1:0] REV_LIMIT_RST   = 8'd1;

	// Result kinds.
	localparam logic KIND_FLUX    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Commands from the controller to the datapath and divider.
	typedef struct packed {
		logic load_in;
		logic mul_en;
		logic sel_rev;
		logic div_start;
		logic cap_sum;
		logic idx_upd;
		logic emit_sum;
		logic emit_flux;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic finished;
		logic index;
		logic rev_active;
		logic pulse_nz;
		logic over;
		logic out_free;
	} status_t;

endpackage

/* hdl/flux_interval_rescaler.sv */
// ----------------------------------------------------------------------------
// Flux interval rescaler
// Rescales flux pulse lengths from a track clock to a 40 MHz sample clock.
// ----------------------------------------------------------------------------
// Usage: input words (new_track, index_before, revolution_ticks, pulse_ticks)
// are taken on in_valid with in_stall low. in_stall is high while a word is
// being worked on; one word is handled at a time. Result words leave on
// out_valid and are held while out_stall is high; each carries kind, the flux
// or summary fields and last on the final result of its input word.
// Timing: a word with a pulse and no summary gives its flux record after one
// division; an index mark that also yields a revolution summary gives the
// summary after one division and delays the flux record by a second one.
// Both come from the shared one-bit-per-cycle divider (58-bit dividend).
// Words giving no result hold in_stall high only through DECIDE and, as
// needed, IDX and PCHK. The output register lets the next word be taken while
// the last result still waits; a stalled receiver holds the controller only
// when a further result is ready to be written.
// Configuration: cfg_ready is always high; index 0 writes track_clock, index 1
// writes revolution_limit. Reset restores track_clock 40000000, limit 1 and
// clears all track state; no result is pending after reset.
// ----------------------------------------------------------------------------
module flux_interval_rescaler (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fir_pkg::TC_W-1:0]          cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              new_track,
	input  logic                              index_before,
	input  logic [fir_pkg::TICKS_W-1:0]       revolution_ticks,
	input  logic [fir_pkg::TICKS_W-1:0]       pulse_ticks,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic [fir_pkg::ZW_W-1:0]          zero_words,
	output logic [fir_pkg::FLUX_W-1:0]        flux_value,
	output logic [fir_pkg::WORD_W-1:0]        rev_clocks,
	output logic [fir_pkg::WORD_W-1:0]        rev_word_count,
	output logic                              done_res,
	output logic                              last
);

	fir_pkg::cmd_t                 cmd;
	fir_pkg::status_t              st;
	logic                          div_done;
	logic [fir_pkg::DIV_W-1:0]     dividend;
	logic [fir_pkg::TC_W-1:0]      divisor;
	logic [fir_pkg::DIV_W-1:0]     quotient;
	logic [fir_pkg::TC_W-1:0]      remainder;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	fir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.div_done (div_done),
		.cmd      (cmd)
	);

	fir_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	fir_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.new_track        (new_track),
		.index_before     (index_before),
		.revolution_ticks (revolution_ticks),
		.pulse_ticks      (pulse_ticks),
		.cmd              (cmd),
		.st               (st),
		.dividend         (dividend),
		.divisor          (divisor),
		.quotient         (quotient),
		.remainder        (remainder),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.kind             (kind),
		.zero_words       (zero_words),
		.flux_value       (flux_value),
		.rev_clocks       (rev_clocks),
		.rev_word_count   (rev_word_count),
		.done_res         (done_res),
		.last             (last)
	);

endmodule

/* hdl/fir_div.sv */
// ----------------------------------------------------------------------------
// Flux interval rescaler divider
// Restoring divider, one quotient bit per cycle, 58-bit dividend by 30 bits.
// ----------------------------------------------------------------------------
`include "flux_interval_rescaler_macros.svh"

module fir_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [fir_pkg::DIV_W-1:0]   dividend,
	input  logic [fir_pkg::TC_W-1:0]    divisor,
	output logic                        done,
	output logic [fir_pkg::DIV_W-1:0]   quotient,
	output logic [fir_pkg::TC_W-1:0]    remainder
);

	logic                        busy_q;
	logic                        done_q;
	logic [fir_pkg::CNT_W-1:0]   cnt_q;
	logic [fir_pkg::DIV_W-1:0]   quo_q;
	logic [fir_pkg::TC_W-1:0]    rem_q;
	logic [fir_pkg::TC_W-1:0]    div_q;
	logic [fir_pkg::TC_W:0]      trial;
	logic [fir_pkg::TC_W+1:0]    diff;
	logic                        borrow;
	logic [fir_pkg::TC_W-1:0]    rem_next;

	// Trial subtraction of the divisor from the shifted partial remainder.
	always_comb begin
		trial    = {rem_q, quo_q[fir_pkg::DIV_W-1]};
		diff     = {1'b0, trial} - {2'b00, div_q};
		borrow   = diff[fir_pkg::TC_W+1];
		rem_next = borrow ? trial[fir_pkg::TC_W-1:0] : diff[fir_pkg::TC_W-1:0];
	end

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == fir_pkg::CNT_W'(fir_pkg::DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[fir_pkg::DIV_W-2:0], ~borrow};
			rem_q <= rem_next;
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`FIR_ASSERT(a_done_pulse, clk, arst_n, done_q |=> !done_q)
	`FIR_ASSERT(a_rem_below_div, clk, arst_n, done_q |-> (rem_q < div_q))
	`FIR_ASSERT(a_no_restart, clk, arst_n, start |-> !busy_q)
	`FIR_ASSERT_ALWAYS(a_done_idle, clk, done_q |-> !busy_q)

endmodule

/* hdl/fir_ctrl.sv */
// ----------------------------------------------------------------------------
// Flux interval rescaler controller
// Sequences one input word through summary and flux conversion steps.
// ----------------------------------------------------------------------------
module fir_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  fir_pkg::status_t  st,
	input  logic              div_done,
	output fir_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_MUL_R,
		S_DIV_R,
		S_WAIT_R,
		S_IDX,
		S_EMIT_S,
		S_PCHK,
		S_MUL_P,
		S_DIV_P,
		S_WAIT_P,
		S_EMIT_F
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   has_sum_q;
	logic   has_sum_d;

	// Next state and commands.
	always_comb begin
		state_d   = state_q;
		has_sum_d = has_sum_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				has_sum_d = st.index && st.rev_active;
				if (st.finished) begin
					state_d = S_IDLE;
				end else if (st.index && st.rev_active) begin
					state_d = S_MUL_R;
				end else if (st.index) begin
					state_d = S_IDX;
				end else begin
					state_d = S_PCHK;
				end
			end
			S_MUL_R: begin
				cmd.mul_en  = 1'b1;
				cmd.sel_rev = 1'b1;
				state_d     = S_DIV_R;
			end
			S_DIV_R: begin
				cmd.div_start = 1'b1;
				cmd.sel_rev   = 1'b1;
				state_d       = S_WAIT_R;
			end
			S_WAIT_R: begin
				if (div_done) begin
					cmd.cap_sum = 1'b1;
					state_d     = S_IDX;
				end
			end
			S_IDX: begin
				cmd.idx_upd = 1'b1;
				if (has_sum_q) begin
					state_d = S_EMIT_S;
				end else if (st.over) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_PCHK;
				end
			end
			S_EMIT_S: begin
				if (st.out_free) begin
					cmd.emit_sum = 1'b1;
					state_d      = st.finished ? S_IDLE : S_PCHK;
				end
			end
			S_PCHK: begin
				state_d = (st.rev_active && st.pulse_nz) ? S_MUL_P : S_IDLE;
			end
			S_MUL_P: begin
				cmd.mul_en = 1'b1;
				state_d    = S_DIV_P;
			end
			S_DIV_P: begin
				cmd.div_start = 1'b1;
				state_d       = S_WAIT_P;
			end
			S_WAIT_P: begin
				if (div_done) begin
					state_d = S_EMIT_F;
				end
			end
			S_EMIT_F: begin
				if (st.out_free) begin
					cmd.emit_flux = 1'b1;
					state_d       = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and summary flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			has_sum_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			has_sum_q <= has_sum_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

/* hdl/fir_datapath.sv */
// ----------------------------------------------------------------------------
// Flux interval rescaler datapath
// Configuration, track state, scaling multiplier and the output register.
// ----------------------------------------------------------------------------
`include "flux_interval_rescaler_macros.svh"

module fir_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration writes.
	input  logic                              cfg_valid,
	input  logic [fir_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [fir_pkg::TC_W-1:0]          cfg_data,
	// Input word.
	input  logic                              new_track,
	input  logic                              index_before,
	input  logic [fir_pkg::TICKS_W-1:0]       revolution_ticks,
	input  logic [fir_pkg::TICKS_W-1:0]       pulse_ticks,
	// Controller link.
	input  fir_pkg::cmd_t                     cmd,
	output fir_pkg::status_t                  st,
	// Divider link.
	output logic [fir_pkg::DIV_W-1:0]         dividend,
	output logic [fir_pkg::TC_W-1:0]          divisor,
	input  logic [fir_pkg::DIV_W-1:0]         quotient,
	input  logic [fir_pkg::TC_W-1:0]          remainder,
	// Output word.
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              kind,
	output logic [fir_pkg::ZW_W-1:0]          zero_words,
	output logic [fir_pkg::FLUX_W-1:0]        flux_value,
	output logic [fir_pkg::WORD_W-1:0]        rev_clocks,
	output logic [fir_pkg::WORD_W-1:0]        rev_word_count,
	output logic                              done_res,
	output logic                              last
);

	logic [fir_pkg::TC_W-1:0]     track_clock_q;
	logic [fir_pkg::LIMIT_W-1:0]  rev_limit_q;
	logic [fir_pkg::REV_W-1:0]    rev_index_q;
	logic [fir_pkg::TC_W-1:0]     carry_q;
	logic [fir_pkg::WORD_W-1:0]   word_count_q;
	logic                         finished_q;
	logic                         index_q;
	logic [fir_pkg::TICKS_W-1:0]  rev_ticks_q;
	logic [fir_pkg::TICKS_W-1:0]  pulse_ticks_q;
	logic [fir_pkg::DIV_W-1:0]    prod_s1;
	logic [fir_pkg::WORD_W-1:0]   sum_clocks_q;
	logic [fir_pkg::WORD_W-1:0]   sum_words_q;
	logic                         sum_done_q;
	logic                         sum_last_q;
	logic                         out_valid_q;
	logic                         kind_q;
	logic [fir_pkg::ZW_W-1:0]     zero_words_q;
	logic [fir_pkg::FLUX_W-1:0]   flux_value_q;
	logic [fir_pkg::WORD_W-1:0]   rev_clocks_q;
	logic [fir_pkg::WORD_W-1:0]   rev_word_count_q;
	logic                         done_res_q;
	logic                         last_q;

	logic [fir_pkg::TC_W-1:0]     tc_eff;
	logic [fir_pkg::TICKS_W-1:0]  mul_opd;
	logic [fir_pkg::DIV_W-1:0]    prod_c;
	logic [fir_pkg::TC_W-1:0]     addend;
	logic [fir_pkg::REV_W-1:0]    rev_next;
	logic                         over;
	logic                         out_free;
	logic [fir_pkg::DIV_W-1:0]    v_adj;
	logic [fir_pkg::ZW_W-1:0]     zw;
	logic [fir_pkg::WORD_W-1:0]   wc_next;

	// A zero track clock divides as one.
	assign tc_eff  = (track_clock_q == '0) ? fir_pkg::TC_W'(1) : track_clock_q;
	assign divisor = tc_eff;

	// Scaling product and the dividend offered to the divider.
	assign mul_opd  = cmd.sel_rev ? rev_ticks_q : pulse_ticks_q;
	assign prod_c   = fir_pkg::DIV_W'(fir_pkg::SAMPLE_CLOCK) * fir_pkg::DIV_W'(mul_opd);
	assign addend   = cmd.sel_rev ? (tc_eff >> 1) : carry_q;
	assign dividend = prod_s1 + fir_pkg::DIV_W'(addend);

	// Index bookkeeping.
	assign rev_next = rev_index_q + 1'b1;
	assign over     = rev_next > fir_pkg::REV_W'(rev_limit_q);

	// Flux word from the quotient: an exact 65536 clamps, the overflow count saturates.
	always_comb begin
		v_adj = (quotient == fir_pkg::FLUX_CLAMP_IN) ? fir_pkg::FLUX_MAX : quotient;
		if (|v_adj[fir_pkg::DIV_W-1:fir_pkg::FLUX_W+fir_pkg::ZW_W]) begin
			zw = fir_pkg::ZW_MAX;
		end else begin
			zw = v_adj[fir_pkg::FLUX_W+fir_pkg::ZW_W-1:fir_pkg::FLUX_W];
		end
		wc_next = word_count_q + fir_pkg::WORD_W'(zw) + fir_pkg::WORD_W'(1);
	end

	assign out_free = !out_valid_q || !out_stall;

	// Status toward the controller.
	always_comb begin
		st.finished   = finished_q;
		st.index      = index_q;
		st.rev_active = (rev_index_q != '0);
		st.pulse_nz   = (pulse_ticks_q != '0);
		st.over       = over;
		st.out_free   = out_free;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_clock_q <= fir_pkg::TRACK_CLOCK_RST;
			rev_limit_q   <= fir_pkg::REV_LIMIT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fir_pkg::CFG_TRACK_CLOCK: track_clock_q <= cfg_data;
				fir_pkg::CFG_REV_LIMIT:   rev_limit_q   <= cfg_data[fir_pkg::LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Track state: revolution index, carried remainder, word count and done flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_index_q  <= '0;
			carry_q      <= '0;
			word_count_q <= '0;
			finished_q   <= 1'b0;
		end else begin
			if (cmd.load_in && new_track) begin
				rev_index_q  <= '0;
				carry_q      <= '0;
				word_count_q <= '0;
				finished_q   <= 1'b0;
			end
			if (cmd.idx_upd) begin
				rev_index_q <= rev_next;
				if (over) begin
					finished_q <= 1'b1;
				end else begin
					word_count_q <= '0;
				end
			end
			if (cmd.emit_flux) begin
				carry_q      <= remainder;
				word_count_q <= wc_next;
			end
		end
	end

	// Input word, product stage and pending summary.
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			index_q       <= index_before;
			rev_ticks_q   <= revolution_ticks;
			pulse_ticks_q <= pulse_ticks;
		end
		if (cmd.mul_en) begin
			prod_s1 <= prod_c;
		end
		if (cmd.cap_sum) begin
			sum_clocks_q <= quotient[fir_pkg::WORD_W-1:0];
			sum_words_q  <= word_count_q;
		end
		if (cmd.idx_upd) begin
			sum_done_q <= over;
			sum_last_q <= over || (pulse_ticks_q == '0);
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_sum || cmd.emit_flux) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.emit_sum) begin
			kind_q           <= fir_pkg::KIND_SUMMARY;
			zero_words_q     <= '0;
			flux_value_q     <= '0;
			rev_clocks_q     <= sum_clocks_q;
			rev_word_count_q <= sum_words_q;
			done_res_q       <= sum_done_q;
			last_q           <= sum_last_q;
		end else if (cmd.emit_flux) begin
			kind_q           <= fir_pkg::KIND_FLUX;
			zero_words_q     <= zw;
			flux_value_q     <= v_adj[fir_pkg::FLUX_W-1:0];
			rev_clocks_q     <= '0;
			rev_word_count_q <= '0;
			done_res_q       <= 1'b0;
			last_q           <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign zero_words     = zero_words_q;
	assign flux_value     = flux_value_q;
	assign rev_clocks     = rev_clocks_q;
	assign rev_word_count = rev_word_count_q;
	assign done_res       = done_res_q;
	assign last           = last_q;

	`FIR_ASSERT(a_emit_into_free, clk, arst_n, (cmd.emit_sum || cmd.emit_flux) |-> out_free)
	`FIR_ASSERT(a_finished_after_index, clk, arst_n, finished_q |-> (rev_index_q != '0))

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flux interval rescaler testbench
// Sends tracks of flux words (new track flags, index marks, revolution and
// pulse lengths) through the rescaler under several track clock and
// revolution limit settings, predicts every flux record and revolution
// summary in step with accepted words, and compares the results field by
// field. Both sides idle and stall at random, with one long receiver hold.
// ----------------------------------------------------------------------------
module tb_top;
	import fir_pkg::*;

	localparam int ITEM_TARGET    = 1950;
	localparam int HOLD_CYCLES    = 800;
	localparam int SETTLE_CYCLES  = 200;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [63:0] SAMPLE_HZ  = 64'd40000000;
	localparam logic [63:0] FLUX_CLAMP = 64'd65536;
	localparam logic [63:0] FLUX_TOP   = 64'd65535;
	localparam logic [63:0] ZW_SAT     = {41'd0, ZW_MAX};

	typedef struct packed {
		logic        new_track;
		logic        index_before;
		logic [31:0] revolution_ticks;
		logic [31:0] pulse_ticks;
	} flux_in_t;

	typedef struct packed {
		logic              kind;
		logic [ZW_W-1:0]   zero_words;
		logic [FLUX_W-1:0] flux_value;
		logic [WORD_W-1:0] rev_clocks;
		logic [WORD_W-1:0] rev_word_count;
		logic              done_res;
		logic              last;
	} flux_rec_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [TC_W-1:0]      cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 new_track = 1'b0;
	logic                 index_before = 1'b0;
	logic [TICKS_W-1:0]   revolution_ticks = '0;
	logic [TICKS_W-1:0]   pulse_ticks = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 kind;
	logic [ZW_W-1:0]      zero_words;
	logic [FLUX_W-1:0]    flux_value;
	logic [WORD_W-1:0]    rev_clocks;
	logic [WORD_W-1:0]    rev_word_count;
	logic                 done_res;
	logic                 last;

	// Words waiting to be sent and records waiting to come back.
	flux_in_t  pending_words[$];
	flux_rec_t predicted_records[$];

	// Predicted block state and configuration.
	logic [TC_W-1:0]    cfg_track_clock = TRACK_CLOCK_RST;
	logic [LIMIT_W-1:0] cfg_rev_limit = REV_LIMIT_RST;
	logic [REV_W-1:0]   rev_number = '0;
	logic [TC_W-1:0]    carry_ticks = '0;
	logic [WORD_W-1:0]  rev_words = '0;
	logic               track_done = 1'b0;

	// Settings the stimulus is generated for.
	logic [TC_W-1:0]    gen_tc = TRACK_CLOCK_RST;
	logic [LIMIT_W-1:0] gen_limit = REV_LIMIT_RST;

	// Run control and statistics.
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	bit hold_served = 1'b0;
	int in_accepts = 0;
	int drv_seen = 0;
	int send_gap = 0;
	int stall_left = 0;
	int stuck_cycles = 0;
	int live_items = 0;
	int results_seen = 0;
	int summaries_seen = 0;
	int config_phases = 0;
	int mismatches = 0;

	flux_interval_rescaler uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.new_track(new_track),
		.index_before(index_before),
		.revolution_ticks(revolution_ticks),
		.pulse_ticks(pulse_ticks),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.zero_words(zero_words),
		.flux_value(flux_value),
		.rev_clocks(rev_clocks),
		.rev_word_count(rev_word_count),
		.done_res(done_res),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Works out the records one accepted word causes and queues them.
	task automatic predict_rescale(input flux_in_t w);
		logic [63:0] tc;
		logic [63:0] t;
		logic [63:0] q;
		logic [63:0] zw;
		flux_rec_t   sum_rec;
		flux_rec_t   flux_rec;
		bit          have_sum;
		bit          have_flux;
		tc = (cfg_track_clock == '0) ? 64'd1 : {34'd0, cfg_track_clock};
		sum_rec = '0;
		flux_rec = '0;
		have_sum = 1'b0;
		have_flux = 1'b0;
		if (w.new_track) begin
			rev_number = '0;
			carry_ticks = '0;
			rev_words = '0;
			track_done = 1'b0;
		end
		if (track_done)
			return;
		live_items++;

		// An index mark closes the running revolution and may end the track.
		if (w.index_before) begin
			if (rev_number != '0) begin
				t = SAMPLE_HZ * {32'd0, w.revolution_ticks} + tc / 64'd2;
				q = t / tc;
				sum_rec.kind = KIND_SUMMARY;
				sum_rec.rev_clocks = q[31:0];
				sum_rec.rev_word_count = rev_words;
				have_sum = 1'b1;
			end
			rev_number = rev_number + 9'd1;
			if (rev_number > {1'b0, cfg_rev_limit}) begin
				track_done = 1'b1;
				sum_rec.done_res = 1'b1;
			end else begin
				rev_words = '0;
			end
		end

		// Rescale the pulse, carrying the division remainder forward.
		if (!track_done && rev_number != '0 && w.pulse_ticks != '0) begin
			t = SAMPLE_HZ * {32'd0, w.pulse_ticks} + {34'd0, carry_ticks};
			q = t % tc;
			carry_ticks = q[TC_W-1:0];
			q = t / tc;
			if (q == FLUX_CLAMP)
				q = FLUX_TOP;
			zw = q >> 16;
			if (zw > ZW_SAT)
				zw = ZW_SAT;
			rev_words = rev_words + zw[31:0] + 32'd1;
			flux_rec.kind = KIND_FLUX;
			flux_rec.zero_words = zw[ZW_W-1:0];
			flux_rec.flux_value = q[FLUX_W-1:0];
			have_flux = 1'b1;
		end

		if (have_flux)
			flux_rec.last = 1'b1;
		else
			sum_rec.last = 1'b1;
		if (have_sum)
			predicted_records.push_back(sum_rec);
		if (have_flux)
			predicted_records.push_back(flux_rec);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	// Monitor: follows register writes, predicts on accepted input words and
	// checks each accepted result word against the oldest prediction.
	always @(posedge clk) begin : monitor
		flux_rec_t want;
		flux_in_t  w;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_TRACK_CLOCK: cfg_track_clock = cfg_data;
					CFG_REV_LIMIT:   cfg_rev_limit = cfg_data[LIMIT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				w.new_track = new_track;
				w.index_before = index_before;
				w.revolution_ticks = revolution_ticks;
				w.pulse_ticks = pulse_ticks;
				predict_rescale(w);
				in_accepts++;
			end
			if (out_valid && !out_stall) begin
				results_seen++;
				if (predicted_records.size() == 0) begin
					$error("result word arrived with nothing predicted");
					mismatches++;
				end else begin
					want = predicted_records.pop_front();
					if (want.kind == KIND_SUMMARY)
						summaries_seen++;
					check_field("kind", want.kind, kind);
					check_field("zero_words", want.zero_words, zero_words);
					check_field("flux_value", want.flux_value, flux_value);
					check_field("rev_clocks", want.rev_clocks, rev_clocks);
					check_field("rev_word_count", want.rev_word_count, rev_word_count);
					check_field("done_res", want.done_res, done_res);
					check_field("last", want.last, last);
				end
			end
		end
	end

	function automatic int pick_gap(input bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(30, 120);
	endfunction

	function automatic int pick_stall(input bit no_idle);
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 80);
	endfunction

	// Driver: offers pending words, holding each until it is taken.
	always @(negedge clk) begin : driver
		flux_in_t w;
		if (!(in_valid && in_accepts == drv_seen)) begin
			drv_seen = in_accepts;
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_words.size() != 0) begin
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				new_track <= w.new_track;
				index_before <= w.index_before;
				revolution_ticks <= w.revolution_ticks;
				pulse_ticks <= w.pulse_ticks;
				send_gap = pick_gap(quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off on request.
	always @(negedge clk) begin : receiver
		if (hold_req && !hold_served) begin
			stall_left = HOLD_CYCLES;
			hold_served = 1'b1;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_stall(quiet);
		end
	end

	// Watchdog: ends the run when no word moves on any channel for too long.
	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$error("timeout: no word accepted for %0d cycles", stuck_cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic push_word(input logic nt, input logic ib, input logic [31:0] rev,
			input logic [31:0] pulse);
		flux_in_t w;
		w.new_track = nt;
		w.index_before = ib;
		w.revolution_ticks = rev;
		w.pulse_ticks = pulse;
		pending_words.push_back(w);
	endtask

	// Pulse lengths aimed at chosen flux values for the current track clock.
	function automatic logic [31:0] rand_pulse();
		int          r;
		logic [63:0] target;
		logic [63:0] p;
		logic [63:0] tc;
		tc = (gen_tc == '0) ? 64'd1 : {34'd0, gen_tc};
		r = $urandom_range(0, 99);
		if (r < 4)
			return 32'd0;
		if (r < 8)
			return $urandom();
		if (r < 12)
			return $urandom_range(1, 3);
		if (r < 22)
			target = 64'd65535 + $urandom_range(0, 2);
		else if (r < 32)
			target = $urandom_range(65538, 400000);
		else
			target = $urandom_range(20, 6000);
		p = target * tc / SAMPLE_HZ + $urandom_range(0, 1);
		return p[31:0];
	endfunction

	// Revolution lengths near 200 ms, with a few arbitrary ones.
	function automatic logic [31:0] rand_rev_ticks();
		int          r;
		logic [63:0] p;
		r = $urandom_range(0, 99);
		if (r < 10)
			return $urandom();
		if (r < 15)
			return $urandom_range(0, 3);
		p = {34'd0, gen_tc} / 64'd5 + $urandom_range(0, 4000);
		return p[31:0];
	endfunction

	task automatic push_noise();
		logic [31:0] pulse;
		pulse = ($urandom_range(0, 3) == 0) ? $urandom() : rand_pulse();
		push_word($urandom_range(0, 7) == 0, $urandom_range(0, 1) != 0,
			$urandom(), pulse);
	endtask

	// One track: optional preamble pulse, index marks with pulses between
	// them, sometimes cut short or run past the limit, with some noise.
	task automatic gen_track();
		int r;
		int revs;
		int k;
		bit lead;
		r = $urandom_range(0, 9);
		if (gen_limit > 12)
			revs = $urandom_range(2, 12);
		else if (r < 6)
			revs = gen_limit + 1;
		else if (r < 8)
			revs = $urandom_range(1, gen_limit + 1);
		else
			revs = gen_limit + 1 + $urandom_range(1, 2);
		lead = $urandom_range(0, 1) != 0;
		if (lead)
			push_word(1'b1, 1'b0, $urandom(), rand_pulse());
		for (k = 0; k < revs; k++) begin
			push_word(k == 0 && !lead, 1'b1, rand_rev_ticks(), rand_pulse());
			repeat ($urandom_range(0, 5)) begin
				if ($urandom_range(0, 14) == 0)
					push_noise();
				push_word(1'b0, 1'b0, $urandom(), rand_pulse());
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TC_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
	endtask

	// Writes both registers; the upper data bits of the limit are junk.
	task automatic setup_phase(input logic [TC_W-1:0] tc, input logic [LIMIT_W-1:0] lim);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(CFG_TRACK_CLOCK, tc);
		write_reg(CFG_REV_LIMIT, {junk[TC_W-1:LIMIT_W], lim});
		@(negedge clk);
		cfg_valid <= 1'b0;
		gen_tc = tc;
		gen_limit = lim;
		config_phases++;
	endtask

	// Waits until every word is sent and every record is back, then lets
	// a trailing word that causes no result finish.
	task automatic wait_drained();
		while (pending_words.size() != 0 || in_valid || predicted_records.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : main
		logic [TC_W-1:0]    tc_pick;
		logic [LIMIT_W-1:0] lim_pick;
		int                 phase_no;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: dropped preamble, flux extremes, clamp at 65536,
		// the limit reached, ignored words, and a restart.
		push_word(1'b1, 1'b0, 32'd0, 32'd1234);
		push_word(1'b0, 1'b1, 32'd123, 32'd0);
		push_word(1'b0, 1'b0, 32'd0, 32'd1);
		push_word(1'b0, 1'b0, 32'd0, 32'd65535);
		push_word(1'b0, 1'b0, 32'd0, 32'd65536);
		push_word(1'b0, 1'b0, 32'd0, 32'd65537);
		push_word(1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF);
		push_word(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd500);
		push_word(1'b0, 1'b1, 32'd5, 32'd77);
		push_word(1'b1, 1'b1, 32'd7, 32'd9);
		wait_drained();

		// Zero track clock and zero limit: the first index ends the track.
		setup_phase('0, 8'd0);
		push_word(1'b1, 1'b0, 32'd0, 32'd5);
		push_word(1'b0, 1'b1, 32'd1, 32'd5);
		push_word(1'b0, 1'b0, 32'd0, 32'd5);
		wait_drained();

		// Zero track clock again: saturated overflow count, huge summary.
		setup_phase('0, 8'd3);
		push_word(1'b1, 1'b1, 32'd0, 32'hFFFF_FFFF);
		push_word(1'b0, 1'b0, 32'd0, 32'd1);
		push_word(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd2);
		wait_drained();

		// Largest track clock and limit: zero flux words, zero length revs.
		setup_phase({TC_W{1'b1}}, 8'd255);
		push_word(1'b1, 1'b1, 32'd0, 32'd3);
		push_word(1'b0, 1'b0, 32'd0, 32'd1000);
		push_word(1'b0, 1'b0, 32'd0, 32'hFFFF_FFFF);
		push_word(1'b0, 1'b1, 32'd0, 32'd0);
		push_word(1'b0, 1'b1, 32'hFFFF_FFFF, 32'd27);
		wait_drained();

		// Random phases, each with fresh settings and several tracks.
		phase_no = 0;
		while (in_accepts < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0: tc_pick = 30'd1000000;
				1: tc_pick = 30'd1000000000;
				2: tc_pick = 30'd40000000;
				3: tc_pick = 30'd25000000;
				4: tc_pick = 30'd48000000;
				5: tc_pick = {TC_W{1'b1}};
				6: tc_pick = $urandom_range(0, 2);
				default: tc_pick = $urandom_range(1000000, 1000000000);
			endcase
			case ($urandom_range(0, 11))
				0: lim_pick = 8'd0;
				1: lim_pick = 8'd255;
				default: lim_pick = $urandom_range(1, 6);
			endcase
			setup_phase(tc_pick, lim_pick);
			quiet = ($urandom_range(0, 4) == 0);
			repeat ($urandom_range(2, 5)) gen_track();
			// Once, the receiver holds off while the sender keeps offering.
			if (phase_no == 2) begin
				quiet = 1'b1;
				hold_req = 1'b1;
			end
			phase_no++;
			wait_drained();
		end

		$display("Sent %0d flux words (%0d on open tracks) under %0d register settings.",
			in_accepts, live_items, config_phases + 1);
		$display("Checked %0d result words, %0d of them revolution summaries.",
			results_seen, summaries_seen);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

/* filelist.f */
+incdir+hdl
hdl/fir_pkg.sv
hdl/fir_div.sv
hdl/fir_ctrl.sv
hdl/fir_datapath.sv
hdl/flux_interval_rescaler.sv
tb/tb_top.sv
